FILE: rtl/iex_pkg.sv
// ----------------------------------------------------------------------------
// iex_pkg
// Shared types and constants of the integer execute unit: opcodes, condition
// codes, fault codes, the decoded micro-op and the sequencer states.
// ----------------------------------------------------------------------------
package iex_pkg;

  localparam int NUM_REGS_DEF = 256;
  localparam int PC_WIDTH_DEF = 16;
  localparam int QDEPTH       = 2;
  localparam int IN_W         = 168;
  localparam int OUT_W        = 96;
  localparam int CFG_W        = 16;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_LAND, OP_LOR, OP_XOR, OP_NEG,
    OP_LNOT, OP_MOV, OP_CMP, OP_CSET, OP_CSEL, OP_JUMP, OP_CASE, OP_RET, OP_TRAP
  } op_e;

  localparam logic [3:0] CC_NONE  = 4'd0;
  localparam logic [3:0] CC_OVF   = 4'd1;
  localparam logic [3:0] CC_CARRY = 4'd2;
  localparam logic [3:0] CC_EQ    = 4'd3;
  localparam logic [3:0] CC_NE    = 4'd4;
  localparam logic [3:0] CC_LT    = 4'd5;
  localparam logic [3:0] CC_GT    = 4'd6;
  localparam logic [3:0] CC_LE    = 4'd7;
  localparam logic [3:0] CC_GE    = 4'd8;
  localparam logic [3:0] CC_TRUE  = 4'd9;
  localparam logic [3:0] CC_FALSE = 4'd10;

  localparam logic [2:0] FAULT_NONE  = 3'd0;
  localparam logic [2:0] FAULT_TRAP  = 3'd1;
  localparam logic [2:0] FAULT_LIMIT = 3'd2;
  localparam logic [2:0] FAULT_DIVZ  = 3'd3;
  localparam logic [2:0] FAULT_COND  = 3'd4;

  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  typedef struct packed {
    op_e         kind;
    logic        chk;
    logic        sgn;
    logic [1:0]  size;
    logic [3:0]  cond;
    logic [7:0]  dest;
    logic        a_from;
    logic [7:0]  a_reg;
    logic [63:0] a_imm;
    logic        b_from;
    logic [7:0]  b_reg;
    logic [63:0] b_imm;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_MULEND, ST_DIV, ST_FIN
  } st_e;

endpackage

FILE: rtl/iex_front.sv
// ----------------------------------------------------------------------------
// iex_front
// Input side: takes instruction beats, unpacks and classifies them into
// micro-ops and pushes them into the issue queue.
// ----------------------------------------------------------------------------
module iex_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [iex_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      push_valid,
  input  logic                      push_ready,
  output iex_pkg::uop_t             push_uop
);

  logic [4:0] req_type;
  logic       seen;

  assign req_type      = s_axis_tdata[4:0];
  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid;

  always_comb begin
    push_uop.kind   = (req_type > iex_pkg::OP_TRAP) ? iex_pkg::OP_TRAP
                                                    : iex_pkg::op_e'(req_type);
    push_uop.cond   = s_axis_tdata[10:7];
    push_uop.chk    = (s_axis_tdata[10:7] == iex_pkg::CC_OVF) ||
                      (s_axis_tdata[10:7] == iex_pkg::CC_CARRY);
    push_uop.sgn    = (s_axis_tdata[10:7] == iex_pkg::CC_OVF);
    push_uop.size   = s_axis_tdata[6:5];
    push_uop.dest   = s_axis_tdata[18:11];
    push_uop.a_from = s_axis_tdata[19];
    push_uop.a_reg  = s_axis_tdata[27:20];
    push_uop.a_imm  = s_axis_tdata[91:28];
    push_uop.b_from = s_axis_tdata[92];
    push_uop.b_reg  = s_axis_tdata[100:93];
    push_uop.b_imm  = s_axis_tdata[164:101];
  end

  // input activity marker
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (s_axis_tvalid && push_ready) begin
      seen <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> seen)
    else $error("beat accepted without marker");

endmodule

FILE: rtl/iex_queue.sv
// ----------------------------------------------------------------------------
// iex_queue
// Short issue queue of decoded micro-ops between the front and back parts.
// ----------------------------------------------------------------------------
module iex_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  iex_pkg::uop_t push_uop,
  output logic          pop_valid,
  input  logic          pop,
  output iex_pkg::uop_t pop_uop
);

  localparam int PW = (iex_pkg::QDEPTH > 1) ? $clog2(iex_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(iex_pkg::QDEPTH + 1);

  iex_pkg::uop_t slots [iex_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(iex_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_uop    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(iex_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(iex_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/iex_div.sv
// ----------------------------------------------------------------------------
// iex_div
// Signed truncating 64-bit divider: restoring, one quotient bit per cycle on
// the magnitudes, then a sign fix-up step.
// ----------------------------------------------------------------------------
module iex_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  logic        busy;
  logic        fix;
  logic [5:0]  cnt;
  logic        nx;
  logic        ny;
  logic [63:0] dq;
  logic [63:0] rr;
  logic [63:0] dv;
  logic [64:0] sh;
  logic [64:0] diff;

  assign sh   = {rr, dq[63]};
  assign diff = sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (start) begin
      nx  <= dividend[63];
      ny  <= divisor[63];
      dq  <= dividend[63] ? 64'd0 - dividend : dividend;
      dv  <= divisor[63] ? 64'd0 - divisor : divisor;
      rr  <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (!diff[64]) begin
        rr <= diff[63:0];
        dq <= {dq[62:0], 1'b1};
      end else begin
        rr <= sh[63:0];
        dq <= {dq[62:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
    end else if (fix) begin
      quot <= (nx ^ ny) ? 64'd0 - dq : dq;
      rem  <= nx ? 64'd0 - rr : rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fix;
      fix  <= busy && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 6'd63)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/iex_back.sv
// ----------------------------------------------------------------------------
// iex_back
// Back part: sequencer that reads operands from the register file, executes
// one micro-op, commits register, flag, counter and budget, and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module iex_back #(
  parameter int NUM_REGS = iex_pkg::NUM_REGS_DEF,
  parameter int PC_WIDTH = iex_pkg::PC_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  iex_pkg::uop_t              q_uop,
  input  logic                       cfg_wr_en,
  input  logic [iex_pkg::CFG_W-1:0]  cfg_wr_data,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [iex_pkg::OUT_W-1:0]  m_data,
  output logic                       m_last
);

  localparam int AW = $clog2(NUM_REGS);

  iex_pkg::st_e  state;
  iex_pkg::st_e  state_next;
  iex_pkg::uop_t u;

  logic [63:0]         regs [NUM_REGS];
  logic [AW-1:0]       raddr0;
  logic [AW-1:0]       raddr1;
  logic [63:0]         rdata0;
  logic [63:0]         rdata1;
  logic                ok_a;
  logic                ok_b;
  logic                ok_d;
  logic [63:0]         opa;
  logic [63:0]         opb;

  logic [PC_WIDTH-1:0] pc;
  logic [15:0]         budget;
  logic                flag;

  logic [63:0]         res_val;
  logic                res_wr;
  logic                res_flag;
  logic [PC_WIDTH-1:0] res_npc;
  logic                res_taken;
  logic                res_fin;
  logic [2:0]          res_fault;
  logic [15:0]         res_budget;

  logic [63:0]         ex_val;
  logic                ex_wr;
  logic                ex_flag;
  logic [PC_WIDTH-1:0] ex_npc;
  logic                ex_taken;
  logic                ex_fin;
  logic [2:0]          ex_fault;
  logic [15:0]         ex_budget;

  logic [63:0]         ax;
  logic [63:0]         ay;
  logic [63:0]         ar;
  logic [63:0]         amask;
  logic                aovf;
  logic [63:0]         aval;

  logic [63:0]         tgt;
  logic [PC_WIDTH-1:0] tpc;
  logic                tback;
  logic [15:0]         bdec;
  logic                go;

  logic [63:0]         mxs;
  logic [63:0]         mys;
  logic                msm;
  logic [63:0]         mx;
  logic [63:0]         my;
  logic                mneg;
  logic [2:0]          mcnt;
  logic [63:0]         pp;
  logic [1:0]          pp_sh;
  logic [127:0]        acc;
  logic [63:0]         mr;
  logic                movf;
  logic [63:0]         mval;

  logic                div_start;
  logic                div_done;
  logic [63:0]         div_q;
  logic [63:0]         div_r;

  logic                load_out;
  logic                mem_we;
  logic                o_valid;
  logic [15:0]         o_npc;
  logic                o_taken;
  logic                o_wr;
  logic [7:0]          o_idx;
  logic [63:0]         o_val;
  logic                o_flag;
  logic                o_fin;
  logic [2:0]          o_fault;

  function automatic logic in_range(input logic [7:0] idx);
    in_range = ({24'd0, idx} < NUM_REGS);
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] sz);
    unique case (sz)
      iex_pkg::SZ_8:  sext = {{56{v[7]}}, v[7:0]};
      iex_pkg::SZ_16: sext = {{48{v[15]}}, v[15:0]};
      iex_pkg::SZ_32: sext = {{32{v[31]}}, v[31:0]};
      default:        sext = v;
    endcase
  endfunction

  function automatic logic [63:0] zext(input logic [63:0] v, input logic [1:0] sz);
    unique case (sz)
      iex_pkg::SZ_8:  zext = {56'd0, v[7:0]};
      iex_pkg::SZ_16: zext = {48'd0, v[15:0]};
      iex_pkg::SZ_32: zext = {32'd0, v[31:0]};
      default:        zext = v;
    endcase
  endfunction

  function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
    slt = ({~a[63], a[62:0]} < {~b[63], b[62:0]});
  endfunction

  iex_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign ok_d = in_range(u.dest);

  // sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    raddr0     = AW'(q_uop.a_reg);
    raddr1     = AW'(q_uop.b_reg);
    load_out   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      iex_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = iex_pkg::ST_READ;
        end
      end
      iex_pkg::ST_READ: begin
        raddr1     = AW'(u.dest);
        state_next = iex_pkg::ST_EXEC;
      end
      iex_pkg::ST_EXEC: begin
        if (u.kind == iex_pkg::OP_MUL) begin
          state_next = iex_pkg::ST_MUL;
        end else if ((u.kind == iex_pkg::OP_DIV || u.kind == iex_pkg::OP_REM) &&
                     opb != 64'd0) begin
          div_start  = 1'b1;
          state_next = iex_pkg::ST_DIV;
        end else begin
          state_next = iex_pkg::ST_FIN;
        end
      end
      iex_pkg::ST_MUL: begin
        if (mcnt == 3'd4) begin
          state_next = iex_pkg::ST_MULEND;
        end
      end
      iex_pkg::ST_MULEND: begin
        state_next = iex_pkg::ST_FIN;
      end
      iex_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = iex_pkg::ST_FIN;
        end
      end
      iex_pkg::ST_FIN: begin
        if (!o_valid || m_ready) begin
          load_out   = 1'b1;
          state_next = iex_pkg::ST_IDLE;
        end
      end
      default: state_next = iex_pkg::ST_IDLE;
    endcase
  end

  assign mem_we = load_out && res_wr && ok_d;

  // checked add and sub
  always_comb begin
    ax    = u.sgn ? sext(opa, u.size) : zext(opa, u.size);
    ay    = u.sgn ? sext(opb, u.size) : zext(opb, u.size);
    ar    = (u.kind == iex_pkg::OP_SUB) ? ax - ay : ax + ay;
    amask = zext('1, u.size);
    if (u.size != iex_pkg::SZ_64) begin
      if (u.sgn) begin
        aovf = (sext(ar, u.size) != ar);
      end else if (u.kind == iex_pkg::OP_SUB) begin
        aovf = (ax < ay);
      end else begin
        aovf = (ar > amask);
      end
      aval = u.sgn ? sext(ar, u.size) : zext(ar, u.size);
    end else begin
      if (u.kind == iex_pkg::OP_SUB) begin
        aovf = u.sgn ? ((ax ^ ay) & (ax ^ ar)) >> 63 != 64'd0 : (ax < ay);
      end else begin
        aovf = u.sgn ? ((ax ^ ar) & (ay ^ ar)) >> 63 != 64'd0 : (ar < ax);
      end
      aval = ar;
    end
  end

  // branch target
  always_comb begin
    tgt   = (u.kind == iex_pkg::OP_CASE) ? opb : opa;
    tpc   = tgt[PC_WIDTH-1:0];
    tback = (tpc <= pc);
    bdec  = budget - 16'd1;
  end

  // combinational execute
  always_comb begin
    ex_val    = '0;
    ex_wr     = 1'b0;
    ex_flag   = flag;
    ex_npc    = pc + PC_WIDTH'(1);
    ex_taken  = 1'b0;
    ex_fin    = 1'b0;
    ex_fault  = iex_pkg::FAULT_NONE;
    ex_budget = budget;
    go        = 1'b0;
    unique case (u.kind)
      iex_pkg::OP_ADD, iex_pkg::OP_SUB: begin
        ex_wr = 1'b1;
        if (u.chk) begin
          ex_val  = aval;
          ex_flag = aovf;
        end else begin
          ex_val = (u.kind == iex_pkg::OP_SUB) ? opa - opb : opa + opb;
        end
      end
      iex_pkg::OP_MUL: ex_wr = 1'b1;
      iex_pkg::OP_DIV, iex_pkg::OP_REM: begin
        if (opb == 64'd0) begin
          ex_fault = iex_pkg::FAULT_DIVZ;
        end else begin
          ex_wr = 1'b1;
        end
      end
      iex_pkg::OP_LAND: begin
        ex_wr  = 1'b1;
        ex_val = {63'd0, (opa != 64'd0) && (opb != 64'd0)};
      end
      iex_pkg::OP_LOR: begin
        ex_wr  = 1'b1;
        ex_val = {63'd0, (opa != 64'd0) || (opb != 64'd0)};
      end
      iex_pkg::OP_XOR: begin
        ex_wr  = 1'b1;
        ex_val = opa ^ opb;
      end
      iex_pkg::OP_NEG: begin
        ex_wr  = 1'b1;
        ex_val = 64'd0 - opa;
      end
      iex_pkg::OP_LNOT: begin
        ex_wr  = 1'b1;
        ex_val = {63'd0, opa == 64'd0};
      end
      iex_pkg::OP_MOV: begin
        ex_wr  = 1'b1;
        ex_val = opa;
      end
      iex_pkg::OP_CMP: begin
        unique case (u.cond)
          iex_pkg::CC_EQ: ex_flag = (opa == opb);
          iex_pkg::CC_NE: ex_flag = (opa != opb);
          iex_pkg::CC_LT: ex_flag = slt(opa, opb);
          iex_pkg::CC_GT: ex_flag = slt(opb, opa);
          iex_pkg::CC_LE: ex_flag = !slt(opb, opa);
          iex_pkg::CC_GE: ex_flag = !slt(opa, opb);
          default:        ex_flag = 1'b0;
        endcase
      end
      iex_pkg::OP_CSET: begin
        ex_wr  = 1'b1;
        ex_val = {63'd0, flag};
      end
      iex_pkg::OP_CSEL: begin
        ex_wr  = 1'b1;
        ex_val = flag ? opa : opb;
      end
      iex_pkg::OP_JUMP: begin
        if (u.cond == iex_pkg::CC_NONE) begin
          go = 1'b1;
        end else if (u.cond == iex_pkg::CC_TRUE) begin
          go = flag;
        end else if (u.cond == iex_pkg::CC_FALSE) begin
          go = !flag;
        end else begin
          ex_fault = iex_pkg::FAULT_COND;
        end
      end
      iex_pkg::OP_CASE: go = ((ok_d ? rdata1 : 64'd0) == opa);
      iex_pkg::OP_RET: begin
        ex_fin = 1'b1;
        ex_npc = pc;
      end
      default: ex_fault = iex_pkg::FAULT_TRAP;
    endcase
    if (go) begin
      if (budget != 16'd0 && tback) begin
        ex_budget = bdec;
      end
      if (budget != 16'd0 && tback && bdec == 16'd0) begin
        ex_fault = iex_pkg::FAULT_LIMIT;
      end else begin
        ex_npc   = tpc;
        ex_taken = 1'b1;
      end
    end
    if (ex_fault != iex_pkg::FAULT_NONE) begin
      ex_npc   = pc;
      ex_wr    = 1'b0;
      ex_taken = 1'b0;
    end
  end

  // multiply operand prep and final wrap
  always_comb begin
    mxs  = u.chk ? (u.sgn ? sext(opa, u.size) : zext(opa, u.size)) : opa;
    mys  = u.chk ? (u.sgn ? sext(opb, u.size) : zext(opb, u.size)) : opb;
    msm  = !u.chk || u.sgn;
    mr   = mneg ? 64'd0 - acc[63:0] : acc[63:0];
    if (u.chk && u.size != iex_pkg::SZ_64) begin
      movf = u.sgn ? (sext(mr, u.size) != mr) : (zext(mr, u.size) != mr);
      mval = u.sgn ? sext(mr, u.size) : zext(mr, u.size);
    end else begin
      if (u.sgn) begin
        movf = (acc[127:64] != 64'd0) ||
               (mneg ? acc[63:0] > {1'b1, 63'd0} : acc[63:0] > {1'b0, {63{1'b1}}});
      end else begin
        movf = (acc[127:64] != 64'd0);
      end
      mval = mr;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (mem_we) begin
      regs[AW'(u.dest)] <= res_val;
    end
    rdata0 <= regs[raddr0];
    rdata1 <= regs[raddr1];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      iex_pkg::ST_IDLE: begin
        if (q_valid) begin
          u    <= q_uop;
          ok_a <= in_range(q_uop.a_reg);
          ok_b <= in_range(q_uop.b_reg);
        end
      end
      iex_pkg::ST_READ: begin
        opa <= u.a_from ? (ok_a ? rdata0 : 64'd0) : u.a_imm;
        opb <= u.b_from ? (ok_b ? rdata1 : 64'd0) : u.b_imm;
      end
      iex_pkg::ST_EXEC: begin
        res_val    <= ex_val;
        res_wr     <= ex_wr;
        res_flag   <= ex_flag;
        res_npc    <= ex_npc;
        res_taken  <= ex_taken;
        res_fin    <= ex_fin;
        res_fault  <= ex_fault;
        res_budget <= ex_budget;
        mx         <= (msm && mxs[63]) ? 64'd0 - mxs : mxs;
        my         <= (msm && mys[63]) ? 64'd0 - mys : mys;
        mneg       <= msm && (mxs[63] ^ mys[63]);
        mcnt       <= '0;
        acc        <= '0;
      end
      iex_pkg::ST_MUL: begin
        pp    <= {32'd0, mcnt[0] ? mx[63:32] : mx[31:0]} *
                 {32'd0, mcnt[1] ? my[63:32] : my[31:0]};
        pp_sh <= {1'b0, mcnt[0]} + {1'b0, mcnt[1]};
        if (mcnt != 3'd0) begin
          acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
        end
        mcnt <= mcnt + 3'd1;
      end
      iex_pkg::ST_MULEND: begin
        res_val <= mval;
        if (u.chk) begin
          res_flag <= movf;
        end
      end
      iex_pkg::ST_DIV: begin
        if (div_done) begin
          res_val <= (u.kind == iex_pkg::OP_DIV) ? div_q : div_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_npc   <= 16'(res_npc);
      o_taken <= res_taken;
      o_wr    <= res_wr && ok_d;
      o_idx   <= (res_wr && ok_d) ? u.dest : 8'd0;
      o_val   <= (res_wr && ok_d) ? res_val : 64'd0;
      o_flag  <= res_flag;
      o_fin   <= res_fin;
      o_fault <= res_fault;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= iex_pkg::ST_IDLE;
      pc      <= '0;
      flag    <= 1'b0;
      budget  <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        pc      <= res_npc;
        flag    <= res_flag;
        budget  <= res_budget;
        o_valid <= 1'b1;
      end else if (m_ready) begin
        o_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        budget <= cfg_wr_data;
      end
    end
  end

  assign m_valid = o_valid;
  assign m_last  = o_fin;
  assign m_data  = {2'd0, o_fault, o_flag, o_val, o_idx, o_wr, o_taken, o_npc};

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == iex_pkg::ST_FIN))
    else $error("register write outside commit");

  assert property (@(posedge clk) disable iff (rst)
    load_out |=> (state == iex_pkg::ST_IDLE) && o_valid)
    else $error("commit did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    (load_out && res_fault != iex_pkg::FAULT_NONE) |-> !mem_we)
    else $error("faulting instruction wrote a register");

  assert property (@(posedge clk) disable iff (rst)
    div_start |-> (u.kind == iex_pkg::OP_DIV || u.kind == iex_pkg::OP_REM))
    else $error("divider started for a non-divide op");

endmodule

FILE: rtl/ir_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// ir_integer_execute_unit
// Integer instruction execute unit with a 64-bit register file, condition
// flag, program counter and backward-branch budget.
// ----------------------------------------------------------------------------
// Instructions are taken into a two-entry queue and executed one at a time by
// a sequencer behind it. A simple instruction passes through the steps
// dequeue, register-file read (registered), execute and commit. A multiply
// adds a step that forms four 32x32 partial products through one multiplier,
// then a wrap step. A divide or remainder runs in the divider, one quotient
// bit per cycle. Results sit in an output register, so the queue keeps
// filling while a result beat waits. Writing cfg_wr_data also reloads the
// branch budget.
module ir_integer_execute_unit #(
  parameter int NUM_REGS = iex_pkg::NUM_REGS_DEF,
  parameter int PC_WIDTH = iex_pkg::PC_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // req_type, size_code, cond_code, dest_reg, a_from_reg, a_reg, a_imm,
  // b_from_reg, b_reg, b_imm
  input  logic [iex_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // next_pc, branch_taken, reg_write, write_index, write_value, flag_now,
  // fault_code
  output logic [iex_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       cfg_wr_en,
  input  logic [iex_pkg::CFG_W-1:0]  cfg_wr_data
);

  logic          push_valid;
  logic          push_ready;
  iex_pkg::uop_t push_uop;
  logic          q_valid;
  logic          q_pop;
  iex_pkg::uop_t q_uop;

  iex_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_uop      (push_uop)
  );

  iex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_uop    (q_uop)
  );

  iex_back #(
    .NUM_REGS (NUM_REGS),
    .PC_WIDTH (PC_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_uop       (q_uop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata),
    .m_last      (m_axis_tlast)
  );

endmodule
